>>> hw/rtl/rbb_pkg.sv
// Shared constants, codes and controller/datapath interface types of the box blur.
package rbb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_KERNEL = 15;

	localparam int DIM_W    = 12;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int KW       = 4;
	localparam int RMOD_W   = $clog2(MAX_KERNEL);
	localparam int RM_W     = $clog2(3 * MAX_KERNEL);
	localparam int RAM_DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int ADDR_W   = $clog2(RAM_DEPTH);
	localparam int PIX_W    = 24;
	localparam int SUM_W    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int DEN_W    = $clog2(MAX_KERNEL * MAX_KERNEL);
	localparam int LAG_W    = $clog2(((MAX_KERNEL - 1) / 2) * MAX_WIDTH + MAX_KERNEL);
	localparam int DCNT_W   = $clog2(SUM_W);
	localparam int CIDX_W   = 2;

	localparam logic [CIDX_W-1:0] CFG_KERNEL = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic accept;
		logic sum_issue;
		logic ctr_issue;
		logic ctr_latch;
		logic div_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit;
		logic interior_now;
		logic interior_q;
		logic sum_last;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> hw/rtl/rbb_ram.sv
// Generic simple dual-port RAM with registered read.
module rbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> hw/rtl/rbb_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module rbb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rbb_pkg::dp_status_t status,
	output rbb_pkg::ctrl_cmd_t  cmd
);
	import rbb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CTR,
		ST_CWAIT,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && status.emit) begin
						state_q <= status.interior_now ? ST_SUM : ST_CTR;
					end
				end
				ST_SUM: begin
					if (status.sum_last) state_q <= ST_CTR;
				end
				ST_CTR:   state_q <= ST_CWAIT;
				ST_CWAIT: state_q <= status.interior_q ? ST_DIV : ST_FIN;
				ST_DIV: begin
					if (status.div_last) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign cmd.accept    = (state_q == ST_IDLE) && in_valid;
	assign cmd.sum_issue = (state_q == ST_SUM);
	assign cmd.ctr_issue = (state_q == ST_CTR);
	assign cmd.ctr_latch = (state_q == ST_CWAIT);
	assign cmd.div_step  = (state_q == ST_DIV);
	assign cmd.out_load  = (state_q == ST_FIN) && status.out_free;
endmodule

>>> hw/rtl/rbb_datapath.sv
// Datapath: configuration, position counters, line store, window sum, divider, output register.
module rbb_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbb_pkg::ctrl_cmd_t          cmd,
	output rbb_pkg::dp_status_t         status,
	input  logic                        cfg_valid,
	input  logic [rbb_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [rbb_pkg::DIM_W-1:0]   cfg_data,
	input  logic                        opcode,
	input  logic [7:0]                  in_blue,
	input  logic [7:0]                  in_green,
	input  logic [7:0]                  in_red,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_blue,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_red,
	output logic                        frame_end
);
	import rbb_pkg::*;

	logic [KW-1:0]    kernel_q;
	logic [DIM_W-1:0] width_q, height_q;

	logic [KW-1:0]    k_eff, a_len, half_len;
	logic             big_k;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [KW+DIM_W-1:0] lag_full;
	logic [LAG_W-1:0] lag;

	logic [DIM_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [RMOD_W-1:0] in_rmod_q;
	logic [LAG_W-1:0]  n_q;
	logic [DIM_W-1:0]  mr_q;
	logic [COL_W-1:0]  mc_q;
	logic [RMOD_W-1:0] mrmod_q;

	logic [KW-1:0]     i_q, j_q;
	logic              acc_v_s1;
	logic              interior_q;
	logic [DEN_W-1:0]  deno_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SUM_W-1:0]  sum_q [3];
	logic [SUM_W-1:0]  dvd_q [3];
	logic [DEN_W-1:0]  rem_q [3];
	logic [SUM_W-1:0]  dvd_nx [3];
	logic [DEN_W-1:0]  rem_nx [3];
	logic [PIX_W-1:0]  center_q;

	logic              wr_en, rd_en, cfg_hit, interior_now, last_pos, col_wrap_in;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [PIX_W-1:0]  wr_data, rd_data;
	logic [RM_W-1:0]   rm_tmp, rm_red;
	logic [COL_W-1:0]  rd_col;

	// Effective configuration after clamping.
	always_comb begin
		k_eff    = (kernel_q > KW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : kernel_q;
		big_k    = (k_eff >= KW'(2));
		a_len    = big_k ? ((k_eff - KW'(1)) >> 1) : '0;
		half_len = big_k ? (k_eff >> 1) : '0;
		w_eff    = (width_q == '0) ? DIM_W'(1) :
		           ((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
		h_eff    = (height_q == '0) ? DIM_W'(1) :
		           ((height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q);
		lag_full = (KW+DIM_W)'(a_len) * (KW+DIM_W)'(w_eff) + (KW+DIM_W)'(a_len);
		lag      = LAG_W'(lag_full);
	end

	always_comb begin
		interior_now = big_k &&
			(mr_q >= DIM_W'(half_len)) &&
			((DIM_W+1)'(mr_q) + (DIM_W+1)'(half_len) < (DIM_W+1)'(h_eff)) &&
			(mc_q >= COL_W'(half_len)) &&
			((DIM_W+1)'(mc_q) + (DIM_W+1)'(half_len) < (DIM_W+1)'(w_eff));
		last_pos    = (mr_q == h_eff - DIM_W'(1)) && (DIM_W'(mc_q) == w_eff - DIM_W'(1));
		col_wrap_in = ((DIM_W+1)'(in_col_q) + (DIM_W+1)'(1) >= (DIM_W+1)'(w_eff));
	end

	assign status.emit         = (n_q >= lag);
	assign status.interior_now = interior_now;
	assign status.interior_q   = interior_q;
	assign status.sum_last     = (i_q == k_eff - KW'(1)) && (j_q == k_eff - KW'(1));
	assign status.div_last     = (dcnt_q == DCNT_W'(SUM_W - 1));
	assign status.out_free     = !out_valid || !out_stall;

	// Line store write: rows are kept modulo the largest window height.
	assign wr_en   = cmd.accept && (in_row_q < h_eff);
	assign wr_data = (opcode == OP_FLUSH) ? '0 : {in_red, in_green, in_blue};
	assign wr_addr = ADDR_W'(in_rmod_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);

	// Window row address, reduced back into the modulo range.
	always_comb begin
		rm_tmp = RM_W'(mrmod_q) + RM_W'(MAX_KERNEL) - RM_W'(half_len) + RM_W'(i_q);
		if (rm_tmp >= RM_W'(2 * MAX_KERNEL)) begin
			rm_red = rm_tmp - RM_W'(2 * MAX_KERNEL);
		end else if (rm_tmp >= RM_W'(MAX_KERNEL)) begin
			rm_red = rm_tmp - RM_W'(MAX_KERNEL);
		end else begin
			rm_red = rm_tmp;
		end
		rd_col = mc_q - COL_W'(half_len) + COL_W'(j_q);
		if (cmd.sum_issue) begin
			rd_addr = ADDR_W'(rm_red) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
		end else begin
			rd_addr = ADDR_W'(mrmod_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(mc_q);
		end
	end
	assign rd_en = cmd.sum_issue || cmd.ctr_issue;

	rbb_ram #(
		.WIDTH(PIX_W),
		.DEPTH(RAM_DEPTH)
	) u_line_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// One restoring division step per channel.
	always_comb begin
		logic [DEN_W:0] trial;
		for (int c = 0; c < 3; c++) begin
			trial = {rem_q[c], dvd_q[c][SUM_W-1]};
			if (trial >= {1'b0, deno_q}) begin
				rem_nx[c] = DEN_W'(trial - {1'b0, deno_q});
				dvd_nx[c] = {dvd_q[c][SUM_W-2:0], 1'b1};
			end else begin
				rem_nx[c] = DEN_W'(trial);
				dvd_nx[c] = {dvd_q[c][SUM_W-2:0], 1'b0};
			end
		end
	end

	assign cfg_hit = cfg_valid &&
		((cfg_index == CFG_KERNEL) || (cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

	// Control state: configuration, positions, loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q   <= KW'(3);
			width_q    <= DIM_W'(640);
			height_q   <= DIM_W'(480);
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_rmod_q  <= '0;
			n_q        <= '0;
			mr_q       <= '0;
			mc_q       <= '0;
			mrmod_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			dcnt_q     <= '0;
			acc_v_s1   <= 1'b0;
			interior_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			acc_v_s1 <= cmd.sum_issue;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_KERNEL: kernel_q <= cfg_data[KW-1:0];
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				interior_q <= interior_now;
				i_q        <= '0;
				j_q        <= '0;
				if (n_q < lag) n_q <= n_q + LAG_W'(1);
				if (col_wrap_in) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + DIM_W'(1);
					in_rmod_q <= (in_rmod_q == RMOD_W'(MAX_KERNEL - 1)) ? '0 :
					             in_rmod_q + RMOD_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (cmd.sum_issue) begin
				if (j_q == k_eff - KW'(1)) begin
					j_q <= '0;
					i_q <= i_q + KW'(1);
				end else begin
					j_q <= j_q + KW'(1);
				end
			end
			if (cmd.ctr_latch) dcnt_q <= '0;
			if (cmd.div_step)  dcnt_q <= dcnt_q + DCNT_W'(1);
			if (cmd.out_load) begin
				out_valid <= 1'b1;
				if (last_pos) begin
					mr_q      <= '0;
					mc_q      <= '0;
					mrmod_q   <= '0;
					in_row_q  <= '0;
					in_col_q  <= '0;
					in_rmod_q <= '0;
					n_q       <= '0;
				end else if ((DIM_W+1)'(mc_q) + (DIM_W+1)'(1) >= (DIM_W+1)'(w_eff)) begin
					mc_q    <= '0;
					mr_q    <= mr_q + DIM_W'(1);
					mrmod_q <= (mrmod_q == RMOD_W'(MAX_KERNEL - 1)) ? '0 :
					           mrmod_q + RMOD_W'(1);
				end else begin
					mc_q <= mc_q + COL_W'(1);
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			// A register write restarts the frame.
			if (cfg_hit) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				in_rmod_q <= '0;
				n_q       <= '0;
				mr_q      <= '0;
				mc_q      <= '0;
				mrmod_q   <= '0;
			end
		end
	end

	// Payload registers: sums, divider and output pixel.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			deno_q <= DEN_W'(DEN_W'(k_eff) * DEN_W'(k_eff) - DEN_W'(1));
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end
		if (acc_v_s1) begin
			for (int c = 0; c < 3; c++) sum_q[c] <= sum_q[c] + SUM_W'(rd_data[8*c +: 8]);
		end
		if (cmd.ctr_latch) begin
			center_q <= rd_data;
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= sum_q[c] - SUM_W'(rd_data[8*c +: 8]);
				rem_q[c] <= '0;
			end
		end
		if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= dvd_nx[c];
				rem_q[c] <= rem_nx[c];
			end
		end
		if (cmd.out_load) begin
			out_blue  <= interior_q ? dvd_q[0][7:0] : center_q[7:0];
			out_green <= interior_q ? dvd_q[1][7:0] : center_q[15:8];
			out_red   <= interior_q ? dvd_q[2][7:0] : center_q[23:16];
			frame_end <= last_pos;
		end
	end
endmodule

>>> hw/rtl/rgb_box_blur_without_center_top.sv
// Top level of the RGB box blur that leaves out the window center.
//
// Pixels enter in raster order, one request at a time, and are written into a line store of
// MAX_KERNEL rows by MAX_WIDTH columns held in a single-port-read RAM. A request that yields
// no result (during the initial lag) is only written. A pass-through result reads the center
// pixel, then waits for a free output register. For an interior result the window is read one
// pixel per cycle through the single RAM read port, then a 16-step restoring divider forms all
// three channel quotients in parallel. The finished result sits in an output register, so
// the next request is taken while it waits. The line store needs no clearing after reset.
module rgb_box_blur_without_center_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [7:0]                 in_blue,
	input  logic [7:0]                 in_green,
	input  logic [7:0]                 in_red,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_blue,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_red,
	output logic                       frame_end,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rbb_pkg::CIDX_W-1:0] cfg_index,
	input  logic [rbb_pkg::DIM_W-1:0]  cfg_data
);
	import rbb_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rbb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	rbb_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.opcode   (opcode),
		.in_blue  (in_blue),
		.in_green (in_green),
		.in_red   (in_red),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_blue (out_blue),
		.out_green(out_green),
		.out_red  (out_red),
		.frame_end(frame_end)
	);
endmodule

>>> hw/rtl/rbb_checker.sv
// Port-level assertions for the box blur top level, with the bind that attaches them.
module rbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_blue,
	input logic [7:0] out_green,
	input logic [7:0] out_red,
	input logic       frame_end
);
	// A held result keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_blue) && $stable(out_green)
			&& $stable(out_red) && $stable(frame_end))
		else $error("stalled result changed");

	// A new result appears only out of a request that was being worked on.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

	// Loading a result frees the input side at once.
	a_rise_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled after result load");
endmodule

bind rgb_box_blur_without_center_top rbb_checker u_rbb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_blue (out_blue),
	.out_green(out_green),
	.out_red  (out_red),
	.frame_end(frame_end)
);
